[hw/rtl/nibble_handshake_link_core_defines.svh]
// assertion macros for the nibble handshake link
`ifndef NIBBLE_HANDSHAKE_LINK_CORE_DEFINES_SVH
`define NIBBLE_HANDSHAKE_LINK_CORE_DEFINES_SVH

// same-cycle implication
`define NHL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nhl assertion failed");

// next-cycle implication
`define NHL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nhl assertion failed");

`endif

[hw/rtl/nhl_pkg.sv]
// shared types, codes and sync tables of the nibble handshake link
package nhl_pkg;

  localparam logic [1:0] OpSample = 2'd0;
  localparam logic [1:0] OpStart  = 2'd1;
  localparam logic [1:0] OpHunt   = 2'd2;

  localparam logic [4:0] StrobeBit = 5'h10;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [5:0] {
    PhIdle = 6'b000001,
    PhHi1  = 6'b000010,
    PhHi2  = 6'b000100,
    PhRead = 6'b001000,
    PhLo1  = 6'b010000,
    PhLo2  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [4:0]  port_drive;
    logic [31:0] rx_word;
    logic        done_res;
    logic        sync_found;
    logic        busy_res;
  } nhl_res_t;

  function automatic logic [3:0] sync_send(input logic [1:0] idx);
    logic [3:0] v;
    unique case (idx)
      2'd0:    v = 4'h0;
      2'd1:    v = 4'hF;
      2'd2:    v = 4'hA;
      default: v = 4'hE;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] sync_expect(input logic [1:0] idx);
    logic [3:0] v;
    unique case (idx)
      2'd0:    v = 4'hF;
      2'd1:    v = 4'h0;
      2'd2:    v = 4'hE;
      default: v = 4'hA;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/nibble_handshake_link_core.sv]
// top level of the nibble handshake link with stream ports and result register
// Each accepted word (a port sample or a start command) is handled in the same
// cycle by the handshake state machine and yields exactly one result word,
// which appears in the output register on the following cycle. One word is
// accepted per clock; the limit is the single state update of the handshake
// machine. The output register takes a new word whenever it is empty or its
// content is being taken, so input and output stall together only when the
// output is held.
module nibble_handshake_link_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tx_word[31:0], size_code[33:32], port_nibble[37:34], port_strobe[38], zero
  input  logic [nhl_pkg::InDataW-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // port_drive[4:0], rx_word[36:5], sync_found[37], busy_res[38], zero
  output logic [nhl_pkg::OutDataW-1:0] m_axis_tdata,
  // done_res
  output logic        m_axis_tlast
);
  import nhl_pkg::*;
  `include "nibble_handshake_link_core_defines.svh"

  logic     in_acc;
  nhl_res_t res;
  nhl_res_t res_q;
  logic     valid_q;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  nhl_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_acc),
    .op_i          (s_axis_tuser),
    .tx_word_i     (s_axis_tdata[31:0]),
    .size_code_i   (s_axis_tdata[33:32]),
    .port_nibble_i (s_axis_tdata[37:34]),
    .port_strobe_i (s_axis_tdata[38]),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = res_q.done_res;
  assign m_axis_tdata  = {1'b0, res_q.busy_res, res_q.sync_found, res_q.rx_word,
                          res_q.port_drive};

  `NHL_ASSERT_NEXT(a_out_after_in, clk_i, rst_ni, in_acc, m_axis_tvalid)
  `NHL_ASSERT_NOW(a_found_is_last, clk_i, rst_ni, m_axis_tvalid && res_q.sync_found,
                  m_axis_tlast && !res_q.busy_res)

endmodule

[hw/rtl/nhl_fsm.sv]
// handshake state machine: state registers and per-word update
module nhl_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          op_i,
  input  logic [31:0]         tx_word_i,
  input  logic [1:0]          size_code_i,
  input  logic [3:0]          port_nibble_i,
  input  logic                port_strobe_i,
  output nhl_pkg::nhl_res_t   res_o
);
  import nhl_pkg::*;
  `include "nibble_handshake_link_core_defines.svh"

  phase_e      phase_q, phase_d;
  logic [31:0] tx_shift_q, tx_shift_d;
  logic [31:0] rx_shift_q, rx_shift_d;
  logic [3:0]  left_q, left_d;
  logic        hunting_q, hunting_d;
  logic [1:0]  sync_idx_q, sync_idx_d;
  logic [4:0]  drive_q, drive_d;
  logic        done, found;

  always_comb begin
    phase_d    = phase_q;
    tx_shift_d = tx_shift_q;
    rx_shift_d = rx_shift_q;
    left_d     = left_q;
    hunting_d  = hunting_q;
    sync_idx_d = sync_idx_q;
    drive_d    = drive_q;
    done       = 1'b0;
    found      = 1'b0;
    if (phase_q == PhIdle) begin
      if (op_i == OpStart) begin
        unique case (size_code_i)
          2'd0: begin
            tx_shift_d = {tx_word_i[3:0], 28'd0};
            left_d     = 4'd1;
          end
          2'd1: begin
            tx_shift_d = {tx_word_i[7:0], 24'd0};
            left_d     = 4'd2;
          end
          2'd2: begin
            tx_shift_d = {tx_word_i[15:0], 16'd0};
            left_d     = 4'd4;
          end
          default: begin
            tx_shift_d = tx_word_i;
            left_d     = 4'd8;
          end
        endcase
        rx_shift_d = '0;
        hunting_d  = 1'b0;
        phase_d    = PhHi1;
      end else if (op_i == OpHunt) begin
        rx_shift_d = '0;
        hunting_d  = 1'b1;
        sync_idx_d = 2'd0;
        phase_d    = PhHi1;
      end
    end else if (op_i == OpSample) begin
      unique case (phase_q)
        PhHi1: begin
          if (port_strobe_i) phase_d = PhHi2;
        end
        PhHi2: begin
          if (port_strobe_i) phase_d = PhRead;
        end
        PhRead: begin
          rx_shift_d = {rx_shift_q[27:0], port_nibble_i};
          drive_d    = StrobeBit |
                       {1'b0, hunting_q ? sync_send(sync_idx_q) : tx_shift_q[31:28]};
          phase_d    = PhLo1;
        end
        PhLo1: begin
          if (!port_strobe_i) phase_d = PhLo2;
        end
        PhLo2: begin
          if (!port_strobe_i) begin
            drive_d = '0;
            phase_d = PhHi1;
            if (hunting_q) begin
              if (rx_shift_q[3:0] == sync_expect(sync_idx_q)) begin
                if (sync_idx_q == 2'd3) begin
                  done       = 1'b1;
                  found      = 1'b1;
                  hunting_d  = 1'b0;
                  sync_idx_d = 2'd0;
                  phase_d    = PhIdle;
                end else begin
                  sync_idx_d = sync_idx_q + 2'd1;
                end
              end else begin
                sync_idx_d = 2'd0;
              end
            end else begin
              tx_shift_d = {tx_shift_q[27:0], 4'd0};
              left_d     = left_q - 4'd1;
              if (left_d == 4'd0) begin
                done    = 1'b1;
                phase_d = PhIdle;
              end
            end
          end
        end
        default: begin
          phase_d = PhIdle;
          drive_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      tx_shift_q <= '0;
      rx_shift_q <= '0;
      left_q     <= '0;
      hunting_q  <= 1'b0;
      sync_idx_q <= '0;
      drive_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      tx_shift_q <= tx_shift_d;
      rx_shift_q <= rx_shift_d;
      left_q     <= left_d;
      hunting_q  <= hunting_d;
      sync_idx_q <= sync_idx_d;
      drive_q    <= drive_d;
    end
  end

  assign res_o.port_drive = drive_d;
  assign res_o.rx_word    = rx_shift_d;
  assign res_o.done_res   = done;
  assign res_o.sync_found = found;
  assign res_o.busy_res   = (phase_d != PhIdle);

  `NHL_ASSERT_NOW(a_found_ends, clk_i, rst_ni, step_i && found, done && phase_d == PhIdle)
  `NHL_ASSERT_NOW(a_drive_lo, clk_i, rst_ni, drive_q != 5'd0,
                  phase_q == PhLo1 || phase_q == PhLo2)
  `NHL_ASSERT_NOW(a_hunt_busy, clk_i, rst_ni, hunting_q, phase_q != PhIdle)
  `NHL_ASSERT_NEXT(a_read_drives, clk_i, rst_ni,
                   step_i && phase_q == PhRead && op_i == OpSample, drive_q[4])

endmodule

[tb/nibble_handshake_link_core_test.sv]
// self-checking stream testbench for the nibble handshake link core
module nibble_handshake_link_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nhl_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [15:0] SyncTxNibbles = 16'hEAF0;
  localparam logic [15:0] SyncRxNibbles = 16'hAE0F;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold = 400;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] tx_word;
    logic [1:0]  size_code;
    logic [3:0]  port_nibble;
    logic        port_strobe;
  } link_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tlast;

  nibble_handshake_link_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  link_word_t pending_words[$];
  link_word_t cur_word;
  link_word_t next_word;
  nhl_res_t results_due[$];
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic word_taken = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;

  // shadow state of the link
  phase_e      ph = PhIdle;
  logic [31:0] tx_sh = '0;
  logic [31:0] rx_sh = '0;
  logic [3:0]  left = '0;
  logic        hunt_on = 1'b0;
  logic [1:0]  sync_pos = '0;
  logic [4:0]  drive = '0;

  function automatic void link_predict(input link_word_t w, output nhl_res_t r);
    logic done;
    logic found;
    logic [3:0] txn;
    int unsigned count;
    done = 1'b0;
    found = 1'b0;
    if (ph == PhIdle) begin
      if (w.op == OpStart) begin
        count = 1 << w.size_code;
        tx_sh = w.tx_word << (32 - 4 * count);
        rx_sh = '0;
        left = count[3:0];
        hunt_on = 1'b0;
        ph = PhHi1;
      end else if (w.op == OpHunt) begin
        rx_sh = '0;
        hunt_on = 1'b1;
        sync_pos = '0;
        ph = PhHi1;
      end
    end else if (w.op == OpSample) begin
      case (ph)
        PhHi1: begin
          if (w.port_strobe) ph = PhHi2;
        end
        PhHi2: begin
          if (w.port_strobe) ph = PhRead;
        end
        PhRead: begin
          txn = hunt_on ? SyncTxNibbles[sync_pos*4 +: 4] : tx_sh[31:28];
          rx_sh = {rx_sh[27:0], w.port_nibble};
          drive = {1'b1, txn};
          ph = PhLo1;
        end
        PhLo1: begin
          if (!w.port_strobe) ph = PhLo2;
        end
        PhLo2: begin
          if (!w.port_strobe) begin
            drive = '0;
            ph = PhHi1;
            if (hunt_on) begin
              if (rx_sh[3:0] == SyncRxNibbles[sync_pos*4 +: 4]) begin
                if (sync_pos == 2'd3) begin
                  done = 1'b1;
                  found = 1'b1;
                  hunt_on = 1'b0;
                  sync_pos = '0;
                  ph = PhIdle;
                end else begin
                  sync_pos = sync_pos + 2'd1;
                end
              end else begin
                sync_pos = '0;
              end
            end else begin
              tx_sh = tx_sh << 4;
              left = left - 4'd1;
              if (left == 4'd0) begin
                done = 1'b1;
                ph = PhIdle;
              end
            end
          end
        end
        default: begin
          ph = PhIdle;
          drive = '0;
        end
      endcase
    end
    r.port_drive = drive;
    r.rx_word = rx_sh;
    r.done_res = done;
    r.sync_found = found;
    r.busy_res = (ph != PhIdle);
  endfunction

  task automatic push_word(input logic [1:0] op, input logic [31:0] txw,
                           input logic [1:0] size, input logic [3:0] nib,
                           input logic strobe);
    link_word_t w;
    w.op = op;
    w.tx_word = txw;
    w.size_code = size;
    w.port_nibble = nib;
    w.port_strobe = strobe;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_sample(input logic strobe, input logic [3:0] nib);
    push_word(OpSample, $urandom, 2'($urandom_range(0, 3)), nib, strobe);
  endtask

  // one full nibble handshake, optionally padded with samples and stray non-sample words that hold the phase
  task automatic send_nibble(input logic [3:0] reply, input bit noisy);
    logic [1:0] stray_op;
    if (noisy) begin
      repeat ($urandom_range(0, 2)) push_sample(1'b0, 4'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        stray_op = 2'($urandom_range(1, 3));
        push_word(stray_op, $urandom, 2'($urandom_range(0, 3)), 4'($urandom), 1'($urandom));
      end
    end
    push_sample(1'b1, 4'($urandom));
    if (noisy) repeat ($urandom_range(0, 1)) push_sample(1'b0, 4'($urandom));
    push_sample(1'b1, 4'($urandom));
    push_sample(1'($urandom_range(0, 1)), reply);
    if (noisy) repeat ($urandom_range(0, 2)) push_sample(1'b1, 4'($urandom));
    push_sample(1'b0, 4'($urandom));
    if (noisy) repeat ($urandom_range(0, 1)) push_sample(1'b1, 4'($urandom));
    push_sample(1'b0, 4'($urandom));
  endtask

  task automatic run_exchange(input logic [1:0] size, input logic [31:0] txw, input bit noisy);
    push_word(OpStart, txw, size, 4'($urandom), 1'($urandom));
    repeat (1 << size) send_nibble(4'($urandom), noisy);
  endtask

  task automatic run_hunt(input bit noisy);
    int unsigned pos;
    int unsigned tries;
    logic [3:0] want;
    logic [3:0] reply;
    pos = 0;
    tries = 0;
    push_word(OpHunt, $urandom, 2'($urandom_range(0, 3)), 4'($urandom), 1'($urandom));
    while (pos < 4) begin
      want = SyncRxNibbles[pos*4 +: 4];
      reply = (tries > 16 || $urandom_range(0, 99) < 85) ? want : 4'($urandom);
      send_nibble(reply, noisy);
      pos = (reply == want) ? pos + 1 : 0;
      tries++;
    end
  endtask

  // random strobes, then 3-high 3-low blocks that finish a nibble from any phase
  task automatic run_broken_exchange();
    logic [1:0] size;
    size = 2'($urandom_range(0, 3));
    push_word(OpStart, $urandom, size, 4'($urandom), 1'($urandom));
    repeat ($urandom_range(1, 6)) push_sample(1'($urandom_range(0, 1)), 4'($urandom));
    repeat (1 << size) begin
      repeat (3) push_sample(1'b1, 4'($urandom));
      repeat (3) push_sample(1'b0, 4'($urandom));
    end
  endtask

  task automatic gen_random(input int unsigned n);
    int unsigned base;
    int unsigned r;
    base = words_queued;
    while (words_queued - base < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_word($urandom_range(0, 1) ? OpSample : OpUnused, $urandom,
                  2'($urandom_range(0, 3)), 4'($urandom), 1'($urandom));
      end else if (r < 55) begin
        run_exchange(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
      end else if (r < 85) begin
        run_hunt(1'($urandom_range(0, 1)));
      end else begin
        run_broken_exchange();
      end
    end
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || results_due.size() != 0) @(negedge clk_i);
  endtask

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        cur_word <= next_word;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= next_word.op;
        s_axis_tdata <= {1'b0, next_word.port_strobe, next_word.port_nibble,
                         next_word.size_code, next_word.tx_word};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // prediction on accepted input words, checking on accepted result words
  always @(posedge clk_i) begin
    nhl_res_t exp_res;
    nhl_res_t got;
    cycle_count++;
    word_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      link_predict(cur_word, exp_res);
      results_due.push_back(exp_res);
      words_taken++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.port_drive = m_axis_tdata[4:0];
      got.rx_word = m_axis_tdata[36:5];
      got.sync_found = m_axis_tdata[37];
      got.busy_res = m_axis_tdata[38];
      got.done_res = m_axis_tlast;
      if (results_due.size() == 0) begin
        if (err_count < 10)
          $display("unexpected result word: drive %h rx %h done %b found %b busy %b",
                   got.port_drive, got.rx_word, got.done_res, got.sync_found, got.busy_res);
        err_count++;
      end else begin
        exp_res = results_due.pop_front();
        if (got !== exp_res) begin
          if (err_count < 10)
            $display("mismatch: expected %h %h %b %b %b, got %h %h %b %b %b",
                     exp_res.port_drive, exp_res.rx_word, exp_res.done_res,
                     exp_res.sync_found, exp_res.busy_res,
                     got.port_drive, got.rx_word, got.done_res, got.sync_found,
                     got.busy_res);
          err_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle samples, unused op, busy starts, extremes, hunt with a miss
    push_sample(1'b1, 4'hF);
    push_word(OpUnused, 32'hFFFF_FFFF, 2'd3, 4'hF, 1'b1);
    push_word(OpStart, 32'hFFFF_FFFF, 2'd0, 4'h0, 1'b0);
    push_word(OpHunt, 32'h0, 2'd3, 4'hF, 1'b1);
    push_sample(1'b1, 4'h0);
    push_word(OpUnused, 32'h0, 2'd0, 4'h0, 1'b0);
    push_sample(1'b1, 4'h0);
    push_sample(1'b1, 4'hF);
    push_word(OpStart, 32'h0, 2'd3, 4'h0, 1'b1);
    push_sample(1'b0, 4'hF);
    push_sample(1'b0, 4'h0);
    push_word(OpHunt, 32'h0, 2'd0, 4'h0, 1'b0);
    send_nibble(4'h3, 1'b0);
    for (int i = 0; i < 4; i++) send_nibble(SyncRxNibbles[i*4 +: 4], 1'b0);
    wait_drained();

    // no idling, with one long receiver hold-off
    hold_req = 1'b1;
    run_exchange(2'd3, 32'h0, 1'b0);
    gen_random(70);
    wait_drained();

    send_idle_pct = 88;
    recv_stall_pct = 0;
    gen_random(70);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 88;
    gen_random(70);
    wait_drained();

    send_idle_pct = 21;
    recv_stall_pct = 21;
    gen_random(70);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
